// File: rtl/tac_pkg.sv
// ---------------------------------------------------------------------------
// tac_pkg: shared types and constants of the terrain aspect unit
// Register indexes, result limits, arctangent table and the sideband word.
// ---------------------------------------------------------------------------
package tac_pkg;

  localparam int DEF_MAX_WIDTH     = 4096;
  localparam int DEF_ELEV_BITS     = 20;
  localparam int DEF_CORDIC_STAGES = 16;

  localparam int CFG_DATA_BITS = 46;
  localparam int CFG_IDX_BITS  = 2;
  localparam int IMG_W_BITS    = 13;
  localparam int IMG_H_BITS    = 16;
  localparam int THR_BITS      = 46;
  localparam int ASPECT_BITS   = 13;

  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SLOPE_THR    = 2'd2;

  localparam logic [IMG_W_BITS-1:0] RST_IMAGE_WIDTH  = 13'd4096;
  localparam logic [IMG_H_BITS-1:0] RST_IMAGE_HEIGHT = 16'd4096;

  localparam logic [ASPECT_BITS-1:0] ASPECT_MAX  = 13'd5760;
  localparam logic [ASPECT_BITS-1:0] ASPECT_FLAT = 13'd2880;

  // angle accumulator, 2^-16 degree units
  localparam int ZW         = 28;
  localparam int PRESHIFT   = 24;
  localparam int HUGE_LOG2  = 24;
  localparam int ANG_SHIFT  = 12;
  localparam logic signed [ZW-1:0] HALF_TURN = 28'sd11796480;
  localparam logic signed [ZW-1:0] ANG_ROUND = 28'sd2048;

  localparam int ATAN_LEN = 24;
  localparam int ATAN_TAB [ATAN_LEN] = '{
    2949120, 1740966, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  function automatic logic signed [ZW-1:0] atan_val(input int i);
    atan_val = ZW'(ATAN_TAB[i]);
  endfunction

  typedef enum logic [1:0] {
    BASE_NONE = 2'd0,
    BASE_POS  = 2'd1,
    BASE_NEG  = 2'd2
  } tac_base_t;

  typedef struct packed {
    logic      flat;
    logic      below;
    tac_base_t base;
    logic      row_end;
    logic      frame_end;
  } tac_side_t;

endpackage

// File: rtl/tac_in_if.sv
// ---------------------------------------------------------------------------
// tac_in_if: elevation sample channel
// Valid/ready channel carrying one elevation sample and a frame start flag.
// ---------------------------------------------------------------------------
interface tac_in_if #(
  parameter int ELEV_BITS = 20
);
  logic                        valid;
  logic                        ready;
  logic signed [ELEV_BITS-1:0] elevation;
  logic                        frame_start;

  modport source (output valid, elevation, frame_start, input ready);
  modport sink   (input valid, elevation, frame_start, output ready);
endinterface

// File: rtl/tac_out_if.sv
// ---------------------------------------------------------------------------
// tac_out_if: aspect result channel
// Valid/ready channel carrying one aspect result and its row/frame marks.
// ---------------------------------------------------------------------------
interface tac_out_if;
  logic        valid;
  logic        ready;
  logic [12:0] aspect;
  logic        no_aspect;
  logic        row_end;
  logic        frame_end;

  modport source (output valid, aspect, no_aspect, row_end, frame_end, input ready);
  modport sink   (input valid, aspect, no_aspect, row_end, frame_end, output ready);
endinterface

// File: rtl/tac_ram.sv
// ---------------------------------------------------------------------------
// tac_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module tac_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// File: rtl/tac_cordic.sv
// ---------------------------------------------------------------------------
// tac_cordic: pipelined vectoring CORDIC
// One micro-rotation per register stage; each stage loads on its enable.
// ---------------------------------------------------------------------------
module tac_cordic
  import tac_pkg::*;
#(
  parameter int STAGES = 16,
  parameter int AW     = 49
) (
  input  logic                  clk,
  input  logic [STAGES-1:0]     ld,
  input  logic signed [AW-1:0]  a_in,
  input  logic signed [AW-1:0]  b_in,
  output logic signed [ZW-1:0]  z_out
);
  logic signed [AW-1:0] a_r [STAGES];
  logic signed [AW-1:0] b_r [STAGES];
  logic signed [ZW-1:0] z_r [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [AW-1:0] a_p, b_p;
    logic signed [ZW-1:0] z_p;

    if (i == 0) begin : g_first
      assign a_p = a_in;
      assign b_p = b_in;
      assign z_p = '0;
    end else begin : g_rest
      assign a_p = a_r[i-1];
      assign b_p = b_r[i-1];
      assign z_p = z_r[i-1];
    end

    // rotate toward the positive b axis, accumulate the angle
    always_ff @(posedge clk) begin
      if (ld[i]) begin
        if (!a_p[AW-1]) begin
          b_r[i] <= b_p + (a_p >>> i);
          a_r[i] <= a_p - (b_p >>> i);
          z_r[i] <= z_p + atan_val(i);
        end else begin
          b_r[i] <= b_p - (a_p >>> i);
          a_r[i] <= a_p + (b_p >>> i);
          z_r[i] <= z_p - atan_val(i);
        end
      end
    end
  end

  assign z_out = z_r[STAGES-1];
endmodule

// File: rtl/terrain_aspect_3x3_unit.sv
// ---------------------------------------------------------------------------
// terrain_aspect_3x3_unit: Horn aspect of an elevation raster
// Line stores, 3x3 window, Horn gradients, threshold test and CORDIC angle.
// ---------------------------------------------------------------------------
//
//  port      | dir | handshake         | word
//  ----------+-----+-------------------+-----------------------------------
//  in_word   | in  | valid/ready       | elevation, frame_start
//  out_word  | out | valid/ready       | aspect, no_aspect, row_end, frame_end
//  cfg_*     | in  | cfg_we, no wait   | cfg_index, cfg_data
//
//  One word enters per clock unless out_word stalls. From accept to result
//  a word passes the line store read, gradient, square and pre-rotation
//  stages, one stage per CORDIC micro-rotation and the output register.
//  Border pixels advance the line stores and window but give no
//  result. Each stage holds when its successor is full and stalled, so a
//  stall loses and repeats nothing and bubbles are squeezed out. Reset clears
//  valid bits, counts and config registers; line store contents are kept.
//
module terrain_aspect_3x3_unit
  import tac_pkg::*;
#(
  parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
  parameter int ELEV_BITS     = DEF_ELEV_BITS,
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
  input  logic                     clk,
  input  logic                     rst_n,
  tac_in_if.sink                   in_word,
  tac_out_if.source                out_word,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int DW  = ELEV_BITS + 3;              // gradient width
  localparam int SW  = 2 * DW;                     // square width
  localparam int MW  = SW + 1;                     // magnitude width
  localparam int TW  = (MW > THR_BITS) ? MW : THR_BITS;
  localparam int AW  = DW + PRESHIFT + 2;          // CORDIC datapath
  localparam int NST = CORDIC_STAGES + 4;          // last stage = output reg
  localparam int CS0 = 4;                          // first CORDIC stage

  // ---------------- configuration registers
  logic [IMG_W_BITS-1:0] img_w_r;
  logic [IMG_H_BITS-1:0] img_h_r;
  logic [THR_BITS-1:0]   thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= RST_IMAGE_WIDTH;
      img_h_r <= RST_IMAGE_HEIGHT;
      thr_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  img_w_r <= cfg_data[IMG_W_BITS-1:0];
        REG_IMAGE_HEIGHT: img_h_r <= cfg_data[IMG_H_BITS-1:0];
        REG_SLOPE_THR:    thr_r   <= cfg_data[THR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // clamped width-1 and height-1 limits
  logic [CW-1:0]         w_m1;
  logic [IMG_H_BITS-1:0] h_m1;

  always_comb begin
    if (int'(img_w_r) < 3) begin
      w_m1 = CW'(2);
    end else if (int'(img_w_r) > MAX_WIDTH) begin
      w_m1 = CW'(MAX_WIDTH - 1);
    end else begin
      w_m1 = CW'(int'(img_w_r) - 1);
    end
    h_m1 = (img_h_r < IMG_H_BITS'(3)) ? IMG_H_BITS'(2) : img_h_r - IMG_H_BITS'(1);
  end

  // ---------------- stage handshake: go[k] means stage k may load
  logic [NST:1]   v_r;
  logic [NST+1:1] go;
  logic [NST:1]   ld;

  always_comb begin
    go[NST+1] = out_word.ready;
    for (int k = NST; k >= 1; k--) begin
      go[k] = !v_r[k] || go[k+1];
    end
    ld[1] = go[1] && in_word.valid;
    for (int k = 2; k <= NST; k++) begin
      ld[k] = go[k] && v_r[k-1];
    end
  end

  assign in_word.ready = go[1];

  // ---------------- stage 0: counts and line store read
  logic [CW-1:0]         col_r;
  logic [IMG_H_BITS-1:0] row_r;
  logic [CW-1:0]         c_cur;
  logic [IMG_H_BITS-1:0] r_cur;
  logic                  row_end0, frame_end0, emit0;

  always_comb begin
    c_cur      = in_word.frame_start ? '0 : col_r;
    r_cur      = in_word.frame_start ? '0 : row_r;
    row_end0   = (c_cur >= w_m1);
    frame_end0 = row_end0 && (r_cur >= h_m1);
    emit0      = (c_cur >= CW'(2)) && (r_cur >= IMG_H_BITS'(2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (ld[1]) begin
      if (row_end0) begin
        col_r <= '0;
        row_r <= frame_end0 ? '0 : r_cur + IMG_H_BITS'(1);
      end else begin
        col_r <= c_cur + CW'(1);
        row_r <= r_cur;
      end
    end
  end

  // ---------------- stage 1: line store data arrives
  logic signed [ELEV_BITS-1:0] x1_r;
  logic [CW-1:0]               c1_r;
  logic                        emit1_r, re1_r, fe1_r;
  logic                        fwd_r;
  logic signed [ELEV_BITS-1:0] fwd_top_r, fwd_mid_r;
  logic [ELEV_BITS-1:0]        up_rd, mid_rd;
  logic signed [ELEV_BITS-1:0] top1, mid1;
  logic                        st_we;

  // the write of the word leaving stage 1 lands on the edge of this read
  assign st_we = ld[2];
  assign top1  = fwd_r ? fwd_top_r : $signed(up_rd);
  assign mid1  = fwd_r ? fwd_mid_r : $signed(mid_rd);

  tac_ram #(.WIDTH(ELEV_BITS), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (st_we),
    .waddr (c1_r),
    .wdata (mid1),
    .re    (ld[1]),
    .raddr (c_cur),
    .rdata (up_rd)
  );

  tac_ram #(.WIDTH(ELEV_BITS), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (st_we),
    .waddr (c1_r),
    .wdata (x1_r),
    .re    (ld[1]),
    .raddr (c_cur),
    .rdata (mid_rd)
  );

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      x1_r      <= in_word.elevation;
      c1_r      <= c_cur;
      emit1_r   <= emit0;
      re1_r     <= row_end0;
      fe1_r     <= frame_end0;
      // same column read and written on one edge: bypass the store
      fwd_r     <= st_we && (c1_r == c_cur);
      fwd_top_r <= mid1;
      fwd_mid_r <= x1_r;
    end
  end

  // ---------------- stage 2: window shift and Horn gradients
  logic signed [ELEV_BITS-1:0] win_r [3][3];
  logic signed [DW-1:0]        dx2_r, dy2_r;
  tac_side_t                   side2_r;
  logic signed [DW-1:0]        col_new, col_old, n_sum, s_sum;

  always_comb begin
    col_new = DW'(top1) + (DW'(mid1) <<< 1) + DW'(x1_r);
    col_old = DW'(win_r[0][1]) + (DW'(win_r[1][1]) <<< 1) + DW'(win_r[2][1]);
    n_sum   = DW'(win_r[0][1]) + (DW'(win_r[0][2]) <<< 1) + DW'(top1);
    s_sum   = DW'(win_r[2][1]) + (DW'(win_r[2][2]) <<< 1) + DW'(x1_r);
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= win_r[k][1];
        win_r[k][1] <= win_r[k][2];
      end
      win_r[0][2] <= top1;
      win_r[1][2] <= mid1;
      win_r[2][2] <= x1_r;
      dx2_r <= col_new - col_old;
      dy2_r <= n_sum - s_sum;
      side2_r <= '{flat: 1'b0, below: 1'b0, base: BASE_NONE,
                   row_end: re1_r, frame_end: fe1_r};
    end
  end

  // ---------------- stage 3: squares, range check, pre-rotation
  logic [SW-1:0]        sqx3_r, sqy3_r;
  logic                 huge3_r;
  logic signed [AW-1:0] a3_r, b3_r;
  tac_side_t            side3_r;
  tac_side_t            side3_nxt;
  logic signed [AW-1:0] a_pre, b_pre;
  logic                 huge2;

  always_comb begin
    a_pre = AW'(dx2_r) <<< PRESHIFT;
    b_pre = AW'(dy2_r) <<< PRESHIFT;
    huge2 = (longint'(dx2_r) >= (longint'(1) <<< HUGE_LOG2)) ||
            (longint'(dx2_r) <= -(longint'(1) <<< HUGE_LOG2)) ||
            (longint'(dy2_r) >= (longint'(1) <<< HUGE_LOG2)) ||
            (longint'(dy2_r) <= -(longint'(1) <<< HUGE_LOG2));
    side3_nxt      = side2_r;
    side3_nxt.flat = (dx2_r == '0) && (dy2_r == '0);
    // fold the lower half plane up, remember the half turn
    if (dy2_r[DW-1]) begin
      side3_nxt.base = dx2_r[DW-1] ? BASE_NEG : BASE_POS;
    end else begin
      side3_nxt.base = BASE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      sqx3_r  <= SW'(dx2_r * dx2_r);
      sqy3_r  <= SW'(dy2_r * dy2_r);
      huge3_r <= huge2;
      side3_r <= side3_nxt;
      if (dy2_r[DW-1]) begin
        a3_r <= -a_pre;
        b3_r <= -b_pre;
      end else begin
        a3_r <= a_pre;
        b3_r <= b_pre;
      end
    end
  end

  // ---------------- stages 4..NST-1: threshold test and CORDIC
  logic [MW-1:0] mag3;
  logic          below3;
  tac_side_t     side4_nxt;
  tac_side_t     side_r [CS0:NST-1];

  always_comb begin
    mag3   = MW'(sqx3_r) + MW'(sqy3_r);
    below3 = !huge3_r && (TW'(mag3) < TW'(thr_r));
    side4_nxt       = side3_r;
    side4_nxt.below = below3;
  end

  always_ff @(posedge clk) begin
    if (ld[CS0]) begin
      side_r[CS0] <= side4_nxt;
    end
    for (int k = CS0 + 1; k < NST; k++) begin
      if (ld[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  logic signed [ZW-1:0] z_end;

  tac_cordic #(.STAGES(CORDIC_STAGES), .AW(AW)) u_cordic (
    .clk   (clk),
    .ld    (ld[NST-1:CS0]),
    .a_in  (a3_r),
    .b_in  (b3_r),
    .z_out (z_end)
  );

  // ---------------- output stage: offset, round, clamp
  logic signed [ZW-1:0]   base_ang, total;
  logic [ZW-1:0]          tot_sh;
  logic [ASPECT_BITS-1:0] asp_nxt;
  logic [ASPECT_BITS-1:0] asp_r;
  tac_side_t              side_o;
  tac_side_t              side_out_r;

  assign side_o = side_r[NST-1];

  always_comb begin
    unique case (side_o.base)
      BASE_POS: base_ang = HALF_TURN;
      BASE_NEG: base_ang = -HALF_TURN;
      default:  base_ang = '0;
    endcase
    total  = HALF_TURN + base_ang + z_end + ANG_ROUND;
    tot_sh = ZW'(total >>> ANG_SHIFT);
    priority if (side_o.below) begin
      asp_nxt = '0;
    end else if (side_o.flat) begin
      asp_nxt = ASPECT_FLAT;
    end else if (total[ZW-1]) begin
      asp_nxt = '0;
    end else if (tot_sh > ZW'(ASPECT_MAX)) begin
      asp_nxt = ASPECT_MAX;
    end else begin
      asp_nxt = tot_sh[ASPECT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[NST]) begin
      asp_r      <= asp_nxt;
      side_out_r <= side_o;
    end
  end

  assign out_word.valid     = v_r[NST];
  assign out_word.aspect    = asp_r;
  assign out_word.no_aspect = side_out_r.below;
  assign out_word.row_end   = side_out_r.row_end;
  assign out_word.frame_end = side_out_r.frame_end;

  // ---------------- valid bits; drop border pixels after the window shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (go[1]) begin
        v_r[1] <= in_word.valid;
      end
      if (go[2]) begin
        v_r[2] <= v_r[1] && emit1_r;
      end
      for (int k = 3; k <= NST; k++) begin
        if (go[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // ---------------- assertions
  a_aspect_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid |-> (out_word.aspect <= ASPECT_MAX))
    else $error("aspect above full turn");

  a_no_aspect_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_word.valid && out_word.no_aspect) |-> (out_word.aspect == '0))
    else $error("aspect not zero on a flagged result");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[NST] |-> in_word.ready)
    else $error("input stalled with an empty output register");

  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_word.valid && out_word.frame_end) |-> out_word.row_end)
    else $error("frame end without row end");

endmodule
